// File: design/login_failure_lockout_table_unit_assert.svh
// Assertion macros for the login lockout table.
`ifndef LOGIN_FAILURE_LOCKOUT_TABLE_UNIT_ASSERT_SVH
`define LOGIN_FAILURE_LOCKOUT_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define LFL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define LFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/lfl_pkg.sv
// Shared types and constants for the login lockout table.
package lfl_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam logic [1:0] VERDICT_ADMIT  = 2'd0;
    localparam logic [1:0] VERDICT_LOCKED = 2'd1;
    localparam logic [1:0] VERDICT_WRONG  = 2'd2;

    localparam logic [1:0] CFG_TRY_LIMIT     = 2'd0;
    localparam logic [1:0] CFG_FAILURE_WIN   = 2'd1;
    localparam logic [1:0] CFG_LOCK_DURATION = 2'd2;

    localparam logic [7:0]  TRY_LIMIT_RST     = 8'd5;
    localparam logic [31:0] FAILURE_WIN_RST   = 32'd300;
    localparam logic [31:0] LOCK_DURATION_RST = 32'd900;

    // Lookup token walking down the cell chain.
    typedef struct packed {
        logic        valid;
        logic        hit;
        logic        free_found;
        logic        locked;
        logic [7:0]  count;
        logic [31:0] last_fail;
        logic [31:0] lock_start;
    } lfl_tok_t;

    // Update command broadcast to all cells.
    typedef struct packed {
        logic        write_en;
        logic        clear_en;
        logic        locked;
        logic [7:0]  count;
        logic [31:0] last_fail;
        logic [31:0] lock_start;
    } lfl_wr_t;

endpackage

// File: design/lfl_in_if.sv
// Login attempt request channel.
interface lfl_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] client_addr;
    logic [31:0] now_s;
    logic        credentials_ok;

    modport source (output valid, output client_addr, output now_s, output credentials_ok,
                    input ready);
    modport sink (input valid, input client_addr, input now_s, input credentials_ok,
                  output ready);
endinterface

// File: design/lfl_out_if.sv
// Login verdict result channel.
interface lfl_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic [7:0] fail_count_now;
    logic       record_dropped;

    modport source (output valid, output verdict, output fail_count_now,
                    output record_dropped, input ready);
    modport sink (input valid, input verdict, input fail_count_now, input record_dropped,
                  output ready);
endinterface

// File: design/lfl_cell.sv
// One table record with its lookup stage in the cell chain.
module lfl_cell #(
    parameter int IDX_W = 4,
    parameter int IDX   = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [31:0]        req_addr,
    input  lfl_pkg::lfl_tok_t  tok_in,
    input  logic [IDX_W-1:0]   hit_idx_in,
    input  logic [IDX_W-1:0]   free_idx_in,
    output lfl_pkg::lfl_tok_t  tok_out,
    output logic [IDX_W-1:0]   hit_idx_out,
    output logic [IDX_W-1:0]   free_idx_out,
    input  lfl_pkg::lfl_wr_t   wr,
    input  logic [IDX_W-1:0]   wr_idx,
    input  logic [IDX_W-1:0]   clr_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic        valid_reg;
    logic [31:0] addr_reg;
    logic        locked_reg;
    logic [7:0]  count_reg;
    logic [31:0] last_fail_reg;
    logic [31:0] lock_start_reg;

    lfl_pkg::lfl_tok_t tok_reg, tok_next;
    logic [IDX_W-1:0]  hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;

    logic me_hit;
    logic me_write;

    assign me_hit   = valid_reg && (addr_reg == req_addr);
    assign me_write = wr.write_en && (wr_idx == MY_IDX);

    always_comb
    begin
        tok_next      = tok_in;
        hit_idx_next  = hit_idx_in;
        free_idx_next = free_idx_in;
        if (tok_in.valid && !tok_in.hit && me_hit)
        begin
            tok_next.hit        = 1'b1;
            tok_next.locked     = locked_reg;
            tok_next.count      = count_reg;
            tok_next.last_fail  = last_fail_reg;
            tok_next.lock_start = lock_start_reg;
            hit_idx_next        = MY_IDX;
        end
        if (tok_in.valid && !tok_in.free_found && !valid_reg)
        begin
            tok_next.free_found = 1'b1;
            free_idx_next       = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (me_write)
                valid_reg <= 1'b1;
            else if (wr.clear_en && (clr_idx == MY_IDX))
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        if (me_write)
        begin
            addr_reg       <= req_addr;
            locked_reg     <= wr.locked;
            count_reg      <= wr.count;
            last_fail_reg  <= wr.last_fail;
            lock_start_reg <= wr.lock_start;
        end
    end

    assign tok_out      = tok_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign free_idx_out = free_idx_reg;

endmodule

// File: design/login_failure_lockout_table_unit.sv
// A request is accepted in the idle state; its lookup token walks the cell chain one record
// per cycle, then the EVAL and UPD states evaluate it and update the table, and UPD waits
// for a free output register. Only one request is in flight at a time.
// A new request is taken while the previous verdict waits in the output register.
// Reset: all records invalid, registers at defaults; no clearing pass is needed.
module login_failure_lockout_table_unit #(
    parameter int TABLE_ENTRIES = lfl_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lfl_in_if.sink      attempt,
    lfl_out_if.source   result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    `include "login_failure_lockout_table_unit_assert.svh"

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [7:0]  try_limit_reg;
    logic [31:0] failure_win_reg;
    logic [31:0] lock_duration_reg;

    logic [31:0] req_addr_reg;
    logic [31:0] req_now_reg;
    logic        req_ok_reg;
    logic        start_reg;

    lfl_pkg::lfl_tok_t tok_chain [0:TABLE_ENTRIES];
    logic [IDX_W-1:0]  hit_chain [0:TABLE_ENTRIES];
    logic [IDX_W-1:0]  free_chain [0:TABLE_ENTRIES];

    lfl_pkg::lfl_tok_t fin_tok_reg;
    logic [IDX_W-1:0]  fin_hit_idx_reg;
    logic [IDX_W-1:0]  fin_free_idx_reg;
    logic              exp_reg;
    logic              win_reg;

    lfl_pkg::lfl_wr_t  wr;
    logic [IDX_W-1:0]  wr_idx;
    logic [IDX_W-1:0]  clr_idx;

    logic        out_valid_reg;
    logic [1:0]  out_verdict_reg, verdict_next;
    logic [7:0]  out_count_reg, count_next;
    logic        out_dropped_reg, dropped_next;

    logic accept;
    logic go;

    assign accept = attempt.valid && attempt.ready;
    assign attempt.ready = (state_reg == ST_IDLE);
    assign go = (state_reg == ST_UPD) && (!out_valid_reg || result.ready);

    always_comb
    begin
        tok_chain[0]       = '0;
        tok_chain[0].valid = start_reg;
        hit_chain[0]       = '0;
        free_chain[0]      = '0;
    end

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        lfl_cell #(
            .IDX_W (IDX_W),
            .IDX   (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .req_addr     (req_addr_reg),
            .tok_in       (tok_chain[i]),
            .hit_idx_in   (hit_chain[i]),
            .free_idx_in  (free_chain[i]),
            .tok_out      (tok_chain[i+1]),
            .hit_idx_out  (hit_chain[i+1]),
            .free_idx_out (free_chain[i+1]),
            .wr           (wr),
            .wr_idx       (wr_idx),
            .clr_idx      (clr_idx)
        );
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_SCAN;
            ST_SCAN: if (tok_chain[TABLE_ENTRIES].valid) state_next = ST_EVAL;
            ST_EVAL: state_next = ST_UPD;
            ST_UPD:  if (go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Verdict and table update
    always_comb
    begin
        logic       refused;
        logic       eff_hit;
        logic       room;
        logic [7:0] base;
        logic [7:0] newc;
        logic       lock_now;
        logic       new_lock;

        refused  = fin_tok_reg.hit && fin_tok_reg.locked && !exp_reg;
        eff_hit  = fin_tok_reg.hit && !exp_reg;
        room     = fin_tok_reg.free_found || exp_reg;
        base     = win_reg ? 8'd0 : fin_tok_reg.count;
        newc     = (base == 8'hFF) ? base : base + 8'd1;
        lock_now = (newc >= try_limit_reg);
        new_lock = (try_limit_reg <= 8'd1);

        wr           = '0;
        wr_idx       = fin_hit_idx_reg;
        clr_idx      = fin_hit_idx_reg;
        verdict_next = lfl_pkg::VERDICT_WRONG;
        count_next   = 8'd0;
        dropped_next = 1'b0;

        if (refused)
        begin
            verdict_next = lfl_pkg::VERDICT_LOCKED;
            count_next   = fin_tok_reg.count;
        end
        else if (req_ok_reg)
        begin
            verdict_next = lfl_pkg::VERDICT_ADMIT;
            wr.clear_en  = fin_tok_reg.hit;
        end
        else if (eff_hit)
        begin
            wr.write_en   = 1'b1;
            wr.count      = newc;
            wr.last_fail  = req_now_reg;
            wr.locked     = lock_now || fin_tok_reg.locked;
            wr.lock_start = lock_now ? req_now_reg : fin_tok_reg.lock_start;
            count_next    = newc;
        end
        else if (!room)
        begin
            dropped_next = 1'b1;
        end
        else
        begin
            // expired record is freed; lowest free slot may be that record
            wr.clear_en   = exp_reg;
            wr.write_en   = 1'b1;
            wr_idx        = (fin_tok_reg.free_found &&
                             (!exp_reg || (fin_free_idx_reg < fin_hit_idx_reg))) ?
                            fin_free_idx_reg : fin_hit_idx_reg;
            wr.count      = 8'd1;
            wr.last_fail  = req_now_reg;
            wr.locked     = new_lock;
            wr.lock_start = new_lock ? req_now_reg : 32'd0;
            count_next    = 8'd1;
        end

        if (!go)
        begin
            wr.write_en = 1'b0;
            wr.clear_en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            start_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
            try_limit_reg     <= lfl_pkg::TRY_LIMIT_RST;
            failure_win_reg   <= lfl_pkg::FAILURE_WIN_RST;
            lock_duration_reg <= lfl_pkg::LOCK_DURATION_RST;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept;
            if (go)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    lfl_pkg::CFG_TRY_LIMIT:     try_limit_reg     <= cfg_data[7:0];
                    lfl_pkg::CFG_FAILURE_WIN:   failure_win_reg   <= cfg_data;
                    lfl_pkg::CFG_LOCK_DURATION: lock_duration_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_addr_reg <= attempt.client_addr;
            req_now_reg  <= attempt.now_s;
            req_ok_reg   <= attempt.credentials_ok;
        end
        if (tok_chain[TABLE_ENTRIES].valid)
        begin
            fin_tok_reg      <= tok_chain[TABLE_ENTRIES];
            fin_hit_idx_reg  <= hit_chain[TABLE_ENTRIES];
            fin_free_idx_reg <= free_chain[TABLE_ENTRIES];
        end
        if (state_reg == ST_EVAL)
        begin
            exp_reg <= fin_tok_reg.hit && fin_tok_reg.locked &&
                       ((req_now_reg - fin_tok_reg.lock_start) >= lock_duration_reg);
            win_reg <= ((req_now_reg - fin_tok_reg.last_fail) >= failure_win_reg);
        end
        if (go)
        begin
            out_verdict_reg <= verdict_next;
            out_count_reg   <= count_next;
            out_dropped_reg <= dropped_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.verdict        = out_verdict_reg;
    assign result.fail_count_now = out_count_reg;
    assign result.record_dropped = out_dropped_reg;

    `LFL_ASSERT_NOW(a_tok_in_scan, clk, rst_n, tok_chain[TABLE_ENTRIES].valid, state_reg == ST_SCAN)
    `LFL_ASSERT_NEXT(a_accept_starts, clk, rst_n, accept, start_reg && (state_reg == ST_SCAN))
    `LFL_ASSERT_NEXT(a_go_loads_out, clk, rst_n, go, out_valid_reg && (state_reg == ST_IDLE))
    `LFL_ASSERT_NOW(a_locked_no_drop, clk, rst_n, out_valid_reg && (out_verdict_reg == lfl_pkg::VERDICT_LOCKED), !out_dropped_reg)

endmodule

// File: dv/tb_login_failure_lockout_table_unit.sv
// Testbench for the login lockout table: directed and random login requests checked against a scoreboard.

typedef struct {
    logic [1:0] verdict;
    logic [7:0] fail_count;
    logic       dropped;
} verdict_t;

class lockout_scoreboard;
    logic [7:0]  try_limit;
    logic [31:0] window_s;
    logic [31:0] lock_s;
    bit          held       [lfl_pkg::TABLE_ENTRIES_DEF];
    logic [31:0] owner      [lfl_pkg::TABLE_ENTRIES_DEF];
    bit          locked     [lfl_pkg::TABLE_ENTRIES_DEF];
    logic [7:0]  fails      [lfl_pkg::TABLE_ENTRIES_DEF];
    logic [31:0] last_fail  [lfl_pkg::TABLE_ENTRIES_DEF];
    logic [31:0] lock_start [lfl_pkg::TABLE_ENTRIES_DEF];
    verdict_t    pending_verdicts [$];
    int          mismatch_count;

    function new();
        try_limit = lfl_pkg::TRY_LIMIT_RST;
        window_s = lfl_pkg::FAILURE_WIN_RST;
        lock_s = lfl_pkg::LOCK_DURATION_RST;
        foreach (held[i])
            held[i] = 1'b0;
        mismatch_count = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] data);
        case (idx)
            lfl_pkg::CFG_TRY_LIMIT:     try_limit = data[7:0];
            lfl_pkg::CFG_FAILURE_WIN:   window_s = data;
            lfl_pkg::CFG_LOCK_DURATION: lock_s = data;
            default: ;
        endcase
    endfunction

    function void note_attempt(logic [31:0] addr, logic [31:0] now, logic ok);
        int          hit;
        int          slot;
        logic [31:0] age;
        verdict_t    want;
        hit = -1;
        slot = -1;
        for (int i = lfl_pkg::TABLE_ENTRIES_DEF - 1; i >= 0; i--)
            if (held[i] && owner[i] == addr)
                hit = i;
        want.verdict = lfl_pkg::VERDICT_WRONG;
        want.fail_count = 8'd0;
        want.dropped = 1'b0;
        if (hit >= 0 && locked[hit]) begin
            age = now - lock_start[hit];
            if (age >= lock_s) begin
                held[hit] = 1'b0;
                hit = -1;
            end
            else begin
                want.verdict = lfl_pkg::VERDICT_LOCKED;
                want.fail_count = fails[hit];
                pending_verdicts.insert(pending_verdicts.size(), want);
                return;
            end
        end
        if (ok) begin
            if (hit >= 0)
                held[hit] = 1'b0;
            want.verdict = lfl_pkg::VERDICT_ADMIT;
        end
        else if (hit >= 0) begin
            age = now - last_fail[hit];
            if (age >= window_s)
                fails[hit] = 8'd0;
            if (fails[hit] != 8'hFF)
                fails[hit] = fails[hit] + 8'd1;
            if (fails[hit] >= try_limit) begin
                locked[hit] = 1'b1;
                lock_start[hit] = now;
            end
            last_fail[hit] = now;
            want.fail_count = fails[hit];
        end
        else begin
            for (int i = lfl_pkg::TABLE_ENTRIES_DEF - 1; i >= 0; i--)
                if (!held[i])
                    slot = i;
            if (slot < 0) begin
                want.dropped = 1'b1;
            end
            else begin
                held[slot] = 1'b1;
                owner[slot] = addr;
                fails[slot] = 8'd1;
                last_fail[slot] = now;
                locked[slot] = (try_limit <= 8'd1);
                lock_start[slot] = now;
                want.fail_count = 8'd1;
            end
        end
        pending_verdicts.insert(pending_verdicts.size(), want);
    endfunction

    task report(string msg);
        if (mismatch_count < 40)
            $display("[%0t] MISMATCH %s", $realtime, msg);
        mismatch_count++;
    endtask

    task check_verdict(logic [1:0] verdict, logic [7:0] fail_count, logic dropped);
        verdict_t want;
        if (pending_verdicts.size() == 0) begin
            report($sformatf("unexpected verdict=%0d count=%0d dropped=%0d",
                             verdict, fail_count, dropped));
            return;
        end
        want = pending_verdicts.pop_front();
        if (verdict !== want.verdict)
            report($sformatf("verdict %0d, want %0d", verdict, want.verdict));
        if (fail_count !== want.fail_count)
            report($sformatf("fail_count_now %0d, want %0d", fail_count, want.fail_count));
        if (dropped !== want.dropped)
            report($sformatf("record_dropped %0d, want %0d", dropped, want.dropped));
    endtask
endclass

module tb_login_failure_lockout_table_unit;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    lfl_in_if  attempt_if();
    lfl_out_if result_if();

    lockout_scoreboard sb;
    bit          calm;
    int          hold_left = 0;
    int          stall_left;
    logic [31:0] clock_s;
    logic [31:0] client_pool [32];

    login_failure_lockout_table_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .attempt   (attempt_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int draw_gap();
        if (calm)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && attempt_if.valid && attempt_if.ready)
            sb.note_attempt(attempt_if.client_addr, attempt_if.now_s,
                            attempt_if.credentials_ok);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
            sb.check_verdict(result_if.verdict, result_if.fail_count_now,
                             result_if.record_dropped);
    end

    // Result side: short random stalls after each result, plus long holds on request.
    initial
    begin
        result_if.ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n) begin
                result_if.ready <= 1'b0;
            end
            else if (hold_left > 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                result_if.ready <= 1'b0;
            end
            else if (result_if.valid && result_if.ready) begin
                stall_left = draw_gap();
                if (stall_left > 0) begin
                    stall_left--;
                    result_if.ready <= 1'b0;
                end
                else begin
                    result_if.ready <= 1'b1;
                end
            end
            else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_attempt(logic [31:0] addr, logic [31:0] now, logic ok);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            attempt_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        attempt_if.valid <= 1'b1;
        attempt_if.client_addr <= addr;
        attempt_if.now_s <= now;
        attempt_if.credentials_ok <= ok;
        @(posedge clk);
        while (!attempt_if.ready)
            @(posedge clk);
    endtask

    task automatic finish_phase();
        attempt_if.valid <= 1'b0;
        @(negedge clk);
        while (sb.pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_limits(logic [7:0] tries, logic [31:0] win, logic [31:0] dur);
        logic [1:0]  idx  [3];
        logic [31:0] data [3];
        idx[0] = lfl_pkg::CFG_TRY_LIMIT;
        idx[1] = lfl_pkg::CFG_FAILURE_WIN;
        idx[2] = lfl_pkg::CFG_LOCK_DURATION;
        data[0] = {24'($urandom), tries};
        data[1] = win;
        data[2] = dur;
        for (int k = 0; k < 3; k++) begin
            cfg_we <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= data[k];
            sb.set_reg(idx[k], data[k]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_directed();
        logic [31:0] t0;
        t0 = 32'hFFFF_FF00;
        for (int i = 0; i < 5; i++)
            send_attempt(32'h0, t0 + i, 1'b0);
        send_attempt(32'h0, t0 + 32'd903, 1'b1);
        send_attempt(32'h0, t0 + 32'd904, 1'b0);
        send_attempt(32'hFFFF_FFFF, 32'd1000, 1'b0);
        send_attempt(32'hFFFF_FFFF, 32'd1300, 1'b0);
        send_attempt(32'hFFFF_FFFF, 32'd1599, 1'b0);
        send_attempt(32'hFFFF_FFFF, 32'd1600, 1'b1);
        send_attempt(32'h0000_1234, 32'd1601, 1'b1);
        // fill the table, last one overflows
        for (int i = 0; i < 16; i++)
            send_attempt({28'hA5C3E71, 4'(i)}, 32'd2000 + i, 1'b0);
    endtask

    task automatic run_random(int n, int pool_n, int max_step, int ok_pct, bit do_hold);
        logic [31:0] addr;
        logic [31:0] last;
        int          r;
        for (int k = 0; k < pool_n; k++)
            client_pool[k] = $urandom;
        client_pool[0] = 32'h0;
        client_pool[1] = 32'hFFFF_FFFF;
        clock_s = $urandom;
        last = client_pool[2];
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            if (i == n / 2) begin
                if (do_hold)
                    hold_left = 150;
                else
                    finish_phase();
            end
            r = $urandom_range(0, 15);
            if (r == 0)
                addr = $urandom;
            else if (r < 8)
                addr = last;
            else
                addr = client_pool[$urandom_range(0, pool_n - 1)];
            if ($urandom_range(0, 31) == 0)
                clock_s = clock_s + $urandom;
            else
                clock_s = clock_s + $urandom_range(0, max_step);
            send_attempt(addr, clock_s, $urandom_range(0, 99) < ok_pct);
            last = addr;
        end
    endtask

    // Needs a zero lock duration so locked records expire and get erased.
    task automatic clear_table();
        logic [31:0] held_addrs [$];
        finish_phase();
        for (int i = 0; i < lfl_pkg::TABLE_ENTRIES_DEF; i++)
            if (sb.held[i])
                held_addrs.insert(held_addrs.size(), sb.owner[i]);
        foreach (held_addrs[k]) begin
            clock_s = clock_s + 32'd1;
            send_attempt(held_addrs[k], clock_s, 1'b1);
        end
    endtask

    // One client fails until the count tops out and locks, then is refused.
    task automatic run_hammer();
        logic [31:0] target;
        target = $urandom;
        clock_s = $urandom;
        for (int i = 0; i < 256; i++) begin
            if (i == 100)
                hold_left = 120;
            clock_s = clock_s + $urandom_range(0, 5);
            send_attempt(target, clock_s, 1'b0);
        end
        send_attempt(target, clock_s + 32'd7, 1'b1);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = lfl_pkg::CFG_TRY_LIMIT;
        cfg_data = 32'h0;
        attempt_if.valid = 1'b0;
        attempt_if.client_addr = 32'h0;
        attempt_if.now_s = 32'h0;
        attempt_if.credentials_ok = 1'b0;
        calm = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        finish_phase();

        program_limits(8'd3, 32'd60, 32'd120);
        run_random(120, 20, 25, 25, 1'b1);
        finish_phase();

        program_limits(8'd1, 32'd0, 32'd0);
        run_random(80, 20, 10, 30, 1'b0);
        clear_table();
        finish_phase();

        program_limits(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_hammer();
        run_random(30, 8, 20, 20, 1'b0);
        finish_phase();

        program_limits(8'($urandom_range(2, 8)), $urandom_range(10, 200),
                       $urandom_range(10, 400));
        run_random(50, 24, 30, 30, 1'b0);
        finish_phase();

        program_limits(8'($urandom_range(2, 8)), $urandom_range(10, 200),
                       $urandom_range(10, 400));
        run_random(50, 12, 40, 20, 1'b1);
        finish_phase();

        repeat (30) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pending_verdicts.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
